/* sv/spq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_FIELD_W = 5;

  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_PEEK   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT_OUT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

/* sv/spq_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response beats.
interface spq_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            func;
  logic signed [spq_pkg::VALUE_W-1:0]    value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

interface spq_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [spq_pkg::VALUE_W-1:0]    result_value;
  logic [1:0]                            status;
  logic                                  is_empty;
  logic [spq_pkg::COUNT_FIELD_W-1:0]     entry_count;

  modport source (output valid, output result_value, output status, output is_empty,
                  output entry_count, input ready);
  modport sink (input valid, input result_value, input status, input is_empty,
                input entry_count, output ready);
endinterface

/* sv/spq_cell.sv */
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module spq_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  spq_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [spq_pkg::VALUE_W-1:0]  left_data,
  input  logic                                left_valid,
  input  logic                                left_keep,
  input  logic signed [spq_pkg::VALUE_W-1:0]  right_data,
  input  logic                                right_valid,
  output logic signed [spq_pkg::VALUE_W-1:0]  data,
  output logic                                valid,
  output logic                                keep
);

  logic signed [spq_pkg::VALUE_W-1:0] data_next;
  logic                               valid_next;

  // An entry stays put when it is less than or equal to the new value, so
  // equal values keep their arrival order.
  assign keep = valid && (data <= ctrl.value);

  always_comb begin
    data_next  = data;
    valid_next = valid;
    case (ctrl.op)
      spq_pkg::OP_INSERT: begin
        valid_next = valid | left_valid;
        if (!keep) begin
          data_next = left_keep ? ctrl.value : left_data;
        end
      end
      spq_pkg::OP_SHIFT_OUT: begin
        data_next  = right_data;
        valid_next = right_valid;
      end
      default: begin
        data_next  = data;
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

/* sv/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// Top level of the sorted min-priority queue built from a chain of cells.
//
//   channel | dir | beat contents
//   --------+-----+------------------------------------------------
//   req     | in  | func, value
//   rsp     | out | result_value, status, is_empty, entry_count
//
// In each request beat every cell compares and shifts in parallel,
// so a new request is taken every cycle while the response register is free.
// The response is registered and appears in the cycle after the request is taken.
// A stalled response holds req.ready low until it is taken.
// Reset (synchronous) empties the queue and drops any pending response.
module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst,
  spq_req_if.sink        req,
  spq_rsp_if.source      rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;

  spq_pkg::cell_ctrl_t ctrl;

  logic signed [spq_pkg::VALUE_W-1:0] cell_data [CAPACITY];
  logic                               cell_valid [CAPACITY];
  logic                               cell_keep [CAPACITY];

  logic                               rsp_valid;
  logic signed [spq_pkg::VALUE_W-1:0] rsp_value;
  logic                               rsp_empty;
  logic [spq_pkg::COUNT_FIELD_W-1:0]  rsp_count;
  spq_pkg::status_t                   rsp_status;
  logic signed [spq_pkg::VALUE_W-1:0] rsp_value_next;
  spq_pkg::status_t                   rsp_status_next;

  assign full   = (count == CNT_W'(CAPACITY));
  assign empty  = (count == '0);
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept = req.valid && req.ready;

  always_comb begin
    ctrl.op         = spq_pkg::OP_HOLD;
    ctrl.value      = req.value;
    count_next      = count;
    rsp_value_next  = '0;
    rsp_status_next = spq_pkg::ST_OK;
    unique case (req.func)
      spq_pkg::FUNC_INSERT: begin
        if (full) begin
          rsp_status_next = spq_pkg::ST_FULL;
        end else begin
          ctrl.op    = accept ? spq_pkg::OP_INSERT : spq_pkg::OP_HOLD;
          count_next = count + 1'b1;
        end
      end
      spq_pkg::FUNC_REMOVE, spq_pkg::FUNC_PEEK: begin
        if (empty) begin
          rsp_value_next  = spq_pkg::EMPTY_VALUE;
          rsp_status_next = spq_pkg::ST_EMPTY;
        end else begin
          rsp_value_next = cell_data[0];
          if (req.func == spq_pkg::FUNC_REMOVE) begin
            ctrl.op    = accept ? spq_pkg::OP_SHIFT_OUT : spq_pkg::OP_HOLD;
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
        rsp_value_next  = '0;
        rsp_status_next = spq_pkg::ST_OK;
      end
    endcase
  end

  // Cell zero sees a left neighbor that always stays in place, so it takes the
  // new value when its own entry moves right; the last cell sees an empty
  // right neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [spq_pkg::VALUE_W-1:0] l_data;
    logic                               l_valid;
    logic                               l_keep;
    logic signed [spq_pkg::VALUE_W-1:0] r_data;
    logic                               r_valid;

    if (i == 0) begin : g_first
      assign l_data  = '0;
      assign l_valid = 1'b1;
      assign l_keep  = 1'b1;
    end else begin : g_mid_left
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_keep  = cell_keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid_right
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_data  (l_data),
      .left_valid (l_valid),
      .left_keep  (l_keep),
      .right_data (r_data),
      .right_valid(r_valid),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .keep       (cell_keep[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      rsp_value  <= rsp_value_next;
      rsp_status <= rsp_status_next;
      rsp_empty  <= (count_next == '0);
      rsp_count  <= spq_pkg::COUNT_FIELD_W'(count_next);
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.result_value = rsp_value;
  assign rsp.status       = rsp_status;
  assign rsp.is_empty     = rsp_empty;
  assign rsp.entry_count  = rsp_count;

endmodule

/* sv/spq_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic signed [spq_pkg::VALUE_W-1:0]  result_value,
  input logic [1:0]                          status,
  input logic                                is_empty,
  input logic [spq_pkg::COUNT_FIELD_W-1:0]   entry_count
);

  // Every accepted request yields a response beat in the next cycle.
  a_req_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("accepted request gave no response");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value) && $stable(status))
    else $error("stalled response changed");

  // An empty report on remove or peek leaves the queue empty and returns -1.
  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == spq_pkg::ST_EMPTY |->
      is_empty && result_value == spq_pkg::EMPTY_VALUE)
    else $error("empty status with wrong payload");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == spq_pkg::ST_FULL |-> !is_empty && result_value == '0)
    else $error("full status with wrong payload");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> entry_count == '0)
    else $error("empty flag with nonzero count");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .result_value(rsp.result_value),
  .status      (rsp.status),
  .is_empty    (rsp.is_empty),
  .entry_count (rsp.entry_count)
);

/* tb/sorted_priority_queue_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the sorted min-priority queue: directed table, then random traffic.
module sorted_priority_queue_test;

  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1425;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD_AT = 250;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic signed [spq_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7fffffff;
  localparam logic signed [spq_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [spq_pkg::VALUE_W-1:0] result_value;
    spq_pkg::status_t                   status;
    logic                               is_empty;
    logic [spq_pkg::COUNT_FIELD_W-1:0]  entry_count;
  } rsp_beat_t;

  typedef struct {
    logic [1:0]                         func;
    logic signed [spq_pkg::VALUE_W-1:0] value;
    int                                 reps;
    bit                                 typed;
    rsp_beat_t                          rsp;
  } stim_row_t;

  logic clk;
  logic rst;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the stored entries, ascending from index 0.
  logic signed [spq_pkg::VALUE_W-1:0] shadow_entries[$];
  rsp_beat_t pending_responses[$];
  stim_row_t directed_rows[$];
  int mismatches = 0;
  int cycles = 0;
  bit sender_burst = 0;
  bit receiver_burst = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic rsp_beat_t predict_response(logic [1:0] f,
                                                 logic signed [spq_pkg::VALUE_W-1:0] v);
    rsp_beat_t r;
    int pos;
    r.result_value = '0;
    r.status = spq_pkg::ST_OK;
    case (f)
      spq_pkg::FUNC_INSERT: begin
        if (shadow_entries.size() >= QUEUE_DEPTH) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          // Equal values go behind the ones already stored.
          pos = 0;
          while (pos < shadow_entries.size() && shadow_entries[pos] <= v) pos++;
          shadow_entries.insert(pos, v);
        end
      end
      spq_pkg::FUNC_REMOVE, spq_pkg::FUNC_PEEK: begin
        if (shadow_entries.size() == 0) begin
          r.result_value = spq_pkg::EMPTY_VALUE;
          r.status = spq_pkg::ST_EMPTY;
        end else begin
          r.result_value = shadow_entries[0];
          if (f == spq_pkg::FUNC_REMOVE) void'(shadow_entries.pop_front());
        end
      end
      default: ;
    endcase
    r.is_empty = (shadow_entries.size() == 0);
    r.entry_count = spq_pkg::COUNT_FIELD_W'(shadow_entries.size());
    return r;
  endfunction

  function automatic void add_row(logic [1:0] f, logic signed [spq_pkg::VALUE_W-1:0] v,
                                  int reps, bit typed = 1'b0, rsp_beat_t rsp = '0);
    stim_row_t row;
    row.func = f;
    row.value = v;
    row.reps = reps;
    row.typed = typed;
    row.rsp = rsp;
    directed_rows.push_back(row);
  endfunction

  task automatic send_item(logic [1:0] f, logic signed [spq_pkg::VALUE_W-1:0] v, bit typed,
                           rsp_beat_t typed_rsp);
    int gap;
    rsp_beat_t predicted;
    gap = sender_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= f;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = predict_response(f, v);
    pending_responses.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_responses.size() != 0);
  endtask

  // Response side: random stalls, bursts with none, and one long hold-off.
  initial begin
    int stall;
    int taken;
    taken = 0;
    forever begin
      if (taken % 150 == 0) receiver_burst = ($urandom_range(0, 3) == 0);
      if (taken == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
      else stall = receiver_burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      taken++;
    end
  end

  always @(posedge clk) begin
    rsp_beat_t got;
    rsp_beat_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.result_value, spq_pkg::status_t'(rsp_ch.status), rsp_ch.is_empty,
              rsp_ch.entry_count};
      if (pending_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: response beat with none expected: value %0d status %0d",
                   $time, got.result_value, got.status,
                   " empty %0b count %0d", got.is_empty, got.entry_count);
      end else begin
        want = pending_responses.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: expected value %0d status %0d empty %0b count %0d,",
                     $time, want.result_value, want.status, want.is_empty,
                     want.entry_count,
                     " got value %0d status %0d empty %0b count %0d",
                     got.result_value, got.status, got.is_empty, got.entry_count);
        end
      end
    end
  end

  initial begin
    logic [1:0] f;
    logic signed [spq_pkg::VALUE_W-1:0] v;
    int roll;
    bit filling;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.func <= spq_pkg::FUNC_INSERT;
    req_ch.value <= '0;

    // Empty queue, the unused code, both extremes, fill to capacity and past it, then remove three.
    add_row(spq_pkg::FUNC_PEEK, 32'sd0, 1, 1'b1,
            '{spq_pkg::EMPTY_VALUE, spq_pkg::ST_EMPTY, 1'b1, 5'd0});
    add_row(spq_pkg::FUNC_REMOVE, 32'sh5a5a5a5a, 1, 1'b1,
            '{spq_pkg::EMPTY_VALUE, spq_pkg::ST_EMPTY, 1'b1, 5'd0});
    add_row(FUNC_UNUSED, VALUE_MAX, 1, 1'b1, '{32'sd0, spq_pkg::ST_OK, 1'b1, 5'd0});
    add_row(spq_pkg::FUNC_INSERT, VALUE_MAX, 1, 1'b1,
            '{32'sd0, spq_pkg::ST_OK, 1'b0, 5'd1});
    add_row(spq_pkg::FUNC_INSERT, VALUE_MIN, 1, 1'b1,
            '{32'sd0, spq_pkg::ST_OK, 1'b0, 5'd2});
    add_row(spq_pkg::FUNC_PEEK, 32'sd0, 1, 1'b1, '{VALUE_MIN, spq_pkg::ST_OK, 1'b0, 5'd2});
    add_row(spq_pkg::FUNC_INSERT, -32'sd1, 1);
    add_row(spq_pkg::FUNC_INSERT, 32'sd0, 1);
    add_row(spq_pkg::FUNC_INSERT, 32'sd5, 2);
    add_row(spq_pkg::FUNC_INSERT, 32'sh55555555, 5);
    add_row(spq_pkg::FUNC_INSERT, 32'shaaaaaaaa, 5);
    add_row(spq_pkg::FUNC_INSERT, 32'sd1, 1, 1'b1,
            '{32'sd0, spq_pkg::ST_FULL, 1'b0, 5'd16});
    add_row(FUNC_UNUSED, 32'sd0, 1, 1'b1, '{32'sd0, spq_pkg::ST_OK, 1'b0, 5'd16});
    add_row(spq_pkg::FUNC_REMOVE, 32'sd0, 3);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      repeat (directed_rows[i].reps)
        send_item(directed_rows[i].func, directed_rows[i].value, directed_rows[i].typed,
                  directed_rows[i].rsp);

    // Random traffic swings between filling up and draining so both ends are reached.
    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) wait_for_drain();
      if (shadow_entries.size() >= QUEUE_DEPTH) filling = 1'b0;
      else if (shadow_entries.size() == 0) filling = 1'b1;
      else if ($urandom_range(0, 19) == 0) filling = ~filling;
      roll = $urandom_range(0, 99);
      if (roll < 3) f = FUNC_UNUSED;
      else if (roll < 13) f = spq_pkg::FUNC_PEEK;
      else if (roll < (filling ? 73 : 33)) f = spq_pkg::FUNC_INSERT;
      else f = spq_pkg::FUNC_REMOVE;
      case ($urandom_range(0, 3))
        0: v = int'($urandom_range(0, 16)) - 8;
        1: begin
          case ($urandom_range(0, 3))
            0: v = VALUE_MIN;
            1: v = VALUE_MAX;
            2: v = 32'sd0;
            default: v = -32'sd1;
          endcase
        end
        default: v = $urandom;
      endcase
      send_item(f, v, 1'b0, '0);
    end

    wait_for_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
